/* hw/rtl/tdws_pkg.sv */
// Shared types and constants for the tile depth and white statistics unit.
package tdws_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MAX_TILE_SIDE = 64;
    localparam int TILE_COLS     = MAX_WIDTH / 2;
    localparam int TC_W          = $clog2(TILE_COLS);
    localparam int DIVIDEND_W    = 28;
    localparam int DIVISOR_W     = 12;
    localparam int DIV_CNT_W     = $clog2(DIVIDEND_W);

    // Configuration register indexes
    localparam logic [2:0] REG_TILE_SIDE     = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_WHITE_LEVEL   = 3'd3;
    localparam logic [2:0] REG_WHITE_PERCENT = 3'd4;

    typedef struct packed {
        logic [6:0]  tile_side;
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic [7:0]  white_level;
        logic [6:0]  white_percent;
    } cfg_t;

    typedef struct packed {
        logic capture;   // latch input item, issue accumulator read
        logic update;    // accumulate, advance raster position
        logic div_step;  // one quotient bit
        logic out_load;  // move finished result to output register
    } cmd_t;

    typedef struct packed {
        logic tile_end;  // current item closes a tile
        logic out_busy;  // output register holds an untaken result
    } status_t;

    typedef struct packed {
        logic [12:0] white;
        logic [27:0] sum;
        logic [15:0] dmax;
        logic [15:0] dmin;
    } acc_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

endpackage

/* hw/rtl/tile_depth_white_stats_unit.sv */
// Top level: configuration registers, controller and datapath.
//
//  channel  | handshake              | payload
//  s_       | s_valid / s_ready      | s_mask_pixel, s_depth_mm, s_frame_start
//  m_       | m_valid / m_ready      | m_tile_col, m_tile_row, m_white_count,
//           |                        | m_marked, m_trimmed_mean_mm
//  cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_wdata
//
// Each pixel item is captured with its accumulator read, then accumulated
// and written back. An item closing a tile then runs the serial division,
// one quotient bit per cycle, and loads the output register. Synchronous
// active-low reset restores register defaults and the raster position;
// accumulators need no clearing. A stalled m_ channel holds the next
// tile-closing item, and with it all later items, as s_ready stays low.
module tile_depth_white_stats_unit
    import tdws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_mask_pixel,
    input  logic [15:0] s_depth_mm,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [8:0]  m_tile_col,
    output logic [8:0]  m_tile_row,
    output logic [12:0] m_white_count,
    output logic        m_marked,
    output logic [15:0] m_trimmed_mean_mm,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_wdata
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tile_side     <= 7'd16;
            cfg_reg.image_width   <= 11'd640;
            cfg_reg.image_height  <= 11'd480;
            cfg_reg.white_level   <= 8'd200;
            cfg_reg.white_percent <= 7'd10;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TILE_SIDE:     cfg_reg.tile_side     <= cfg_wdata[6:0];
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_wdata;
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_wdata;
                REG_WHITE_LEVEL:   cfg_reg.white_level   <= cfg_wdata[7:0];
                REG_WHITE_PERCENT: cfg_reg.white_percent <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    tdws_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tdws_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .cmd               (cmd),
        .status            (status),
        .s_mask_pixel      (s_mask_pixel),
        .s_depth_mm        (s_depth_mm),
        .s_frame_start     (s_frame_start),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tile_col        (m_tile_col),
        .m_tile_row        (m_tile_row),
        .m_white_count     (m_white_count),
        .m_marked          (m_marked),
        .m_trimmed_mean_mm (m_trimmed_mean_mm)
    );

endmodule

/* hw/rtl/tdws_ctrl.sv */
// Controller state machine sequencing capture, update, divide and output.
module tdws_ctrl
    import tdws_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                cnt_next   = '0;
                state_next = status.tile_end ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_tile_end_divides: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && status.tile_end) |=> (state_reg == ST_DIVIDE))
        else $error("tile end did not start division");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> (cnt_reg < DIV_CNT_W'(DIVIDEND_W)))
        else $error("division step count overran");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !status.out_busy)
        else $error("result loaded over an untaken result");

endmodule

/* hw/rtl/tdws_datapath.sv */
// Datapath: raster counters, accumulator memory, serial divider, output register.
module tdws_datapath
    import tdws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [7:0]  s_mask_pixel,
    input  logic [15:0] s_depth_mm,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [8:0]  m_tile_col,
    output logic [8:0]  m_tile_row,
    output logic [12:0] m_white_count,
    output logic        m_marked,
    output logic [15:0] m_trimmed_mean_mm
);

    acc_t acc_mem [TILE_COLS];
    acc_t rd_reg;

    logic [7:0]  mask_reg;
    logic [15:0] depth_reg;
    logic        start_reg;

    logic [9:0] pcol_reg, prow_reg, tci_reg, tri_reg;
    logic [5:0] cit_reg, rit_reg;

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg, dvs_reg;
    logic [12:0]           white_reg, area_reg;
    logic [8:0]            tcol_reg, trow_reg;
    logic                  m_valid_reg;

    // Clamped configuration
    logic [6:0]  side;
    logic [10:0] w, h;
    always_comb begin
        side = cfg.tile_side;
        if (side < 7'd2) side = 7'd2;
        else if (side > 7'(MAX_TILE_SIDE)) side = 7'(MAX_TILE_SIDE);
        w = cfg.image_width;
        if (w < 11'd2) w = 11'd2;
        else if (w > 11'(MAX_WIDTH)) w = 11'(MAX_WIDTH);
        h = cfg.image_height;
        if (h < 11'd2) h = 11'd2;
        else if (h > 11'(MAX_HEIGHT)) h = 11'(MAX_HEIGHT);
    end

    // Update-stage values; frame start zeroes the position first
    logic [9:0]  pcol, prow, tci, tri_c;
    logic [5:0]  cit, rit;
    logic [17:0] col_end, row_end;
    logic        in_tile, first, wh, tile_end;
    acc_t        acc_new;
    logic [16:0] ext;
    logic [DIVIDEND_W-1:0] dividend;
    logic [12:0] area;

    always_comb begin
        pcol  = start_reg ? '0 : pcol_reg;
        prow  = start_reg ? '0 : prow_reg;
        tci   = start_reg ? '0 : tci_reg;
        tri_c = start_reg ? '0 : tri_reg;
        cit   = start_reg ? '0 : cit_reg;
        rit   = start_reg ? '0 : rit_reg;
        col_end = 18'({1'b0, tci} + 11'd1) * 18'(side);
        row_end = 18'({1'b0, tri_c} + 11'd1) * 18'(side);
        in_tile = (7'(cit) < side) && (7'(rit) < side) && (tci < 10'(TILE_COLS))
                  && (col_end <= 18'(w)) && (row_end <= 18'(h));
        first = (cit == '0) && (rit == '0);
        wh    = (mask_reg >= cfg.white_level);
        if (first) begin
            acc_new.white = 13'(wh);
            acc_new.sum   = 28'(depth_reg);
            acc_new.dmax  = depth_reg;
            acc_new.dmin  = depth_reg;
        end else begin
            acc_new.white = rd_reg.white + 13'(wh);
            acc_new.sum   = rd_reg.sum + 28'(depth_reg);
            acc_new.dmax  = (depth_reg > rd_reg.dmax) ? depth_reg : rd_reg.dmax;
            acc_new.dmin  = (depth_reg < rd_reg.dmin) ? depth_reg : rd_reg.dmin;
        end
        tile_end = in_tile && (7'(cit) == side - 7'd1) && (7'(rit) == side - 7'd1);
        ext      = 17'(acc_new.dmax) + 17'(acc_new.dmin);
        dividend = (acc_new.sum >= 28'(ext)) ? acc_new.sum - 28'(ext) : '0;
        area     = 13'(side) * 13'(side);
    end

    assign status.tile_end = tile_end;
    assign status.out_busy = m_valid_reg && !m_ready;

    // Accumulator memory
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_reg <= acc_mem[s_frame_start ? '0 : tci_reg[TC_W-1:0]];
        end
        if (cmd.update && in_tile) begin
            acc_mem[tci[TC_W-1:0]] <= acc_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mask_reg  <= s_mask_pixel;
            depth_reg <= s_depth_mm;
            start_reg <= s_frame_start;
        end
    end

    // Raster position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcol_reg <= '0;
            prow_reg <= '0;
            tci_reg  <= '0;
            tri_reg  <= '0;
            cit_reg  <= '0;
            rit_reg  <= '0;
        end else if (cmd.update) begin
            if (11'(pcol) >= w - 11'd1) begin
                pcol_reg <= '0;
                cit_reg  <= '0;
                tci_reg  <= '0;
                if (11'(prow) >= h - 11'd1) begin
                    prow_reg <= '0;
                    rit_reg  <= '0;
                    tri_reg  <= '0;
                end else begin
                    prow_reg <= prow + 10'd1;
                    if (7'(rit) >= side - 7'd1) begin
                        rit_reg <= '0;
                        tri_reg <= tri_c + 10'd1;
                    end else begin
                        rit_reg <= rit + 6'd1;
                        tri_reg <= tri_c;
                    end
                end
            end else begin
                pcol_reg <= pcol + 10'd1;
                prow_reg <= prow;
                rit_reg  <= rit;
                tri_reg  <= tri_c;
                if (7'(cit) >= side - 7'd1) begin
                    cit_reg <= '0;
                    tci_reg <= tci + 10'd1;
                end else begin
                    cit_reg <= cit + 6'd1;
                    tci_reg <= tci;
                end
            end
        end
    end

    // Restoring divider, one quotient bit per step
    logic [DIVISOR_W:0] rem_sh;
    assign rem_sh = {rem_reg, quo_reg[DIVIDEND_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.update && tile_end) begin
            quo_reg   <= dividend;
            rem_reg   <= '0;
            dvs_reg   <= DIVISOR_W'(area - 13'd2);
            white_reg <= acc_new.white;
            area_reg  <= area;
            tcol_reg  <= tci[8:0];
            trow_reg  <= tri_c[8:0];
        end else if (cmd.div_step) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_reg <= DIVISOR_W'(rem_sh - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    // Output register
    logic [19:0] white_x100, pct_area;
    assign white_x100 = 20'(white_reg) * 20'd100;
    assign pct_area   = 20'(cfg.white_percent) * 20'(area_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tile_col        <= tcol_reg;
            m_tile_row        <= trow_reg;
            m_white_count     <= white_reg;
            m_marked          <= (white_x100 >= pct_area);
            m_trimmed_mean_mm <= quo_reg[15:0];
        end
    end

    assign m_valid = m_valid_reg;

endmodule
